@@ design/btlv_pkg.sv @@
package btlv_pkg;

   // Limits of the parser
   localparam int TAG_BYTES_MAX = 4;
   localparam int RECORDS_MAX   = 32;

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int REC_NUM_W   = 5;
   localparam int TAG_W       = 32;
   localparam int LEN_W       = 16;
   localparam int ERR_W       = 3;
   localparam int TAG_SEEN_W  = 3;
   localparam int LEN_LEFT_W  = 2;
   localparam int REC_CNT_W   = $clog2(RECORDS_MAX + 1);
   localparam int CSR_IDX_W   = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_MODE = 1'd1;

   // Byte labels
   localparam logic [KIND_W-1:0] KIND_TAG     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEN     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_TAG_LONG  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TRUNC     = 3'd3;
   localparam logic [ERR_W-1:0] ERR_RECORDS   = 3'd4;

   // BER markers
   localparam logic [4:0]        TAG_MORE_MARK = 5'h1F;
   localparam logic [BYTE_W-1:0] LEN_LONG_1    = 8'h81;
   localparam logic [BYTE_W-1:0] LEN_LONG_2    = 8'h82;

   typedef struct packed {
      logic tag_mode;
      logic len_mode;
   } btlv_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    byte_out;
      logic [KIND_W-1:0]    byte_kind;
      logic [REC_NUM_W-1:0] record_number;
      logic [TAG_W-1:0]     tag_value;
      logic [LEN_W-1:0]     value_length;
      logic                 record_done;
      logic [ERR_W-1:0]     error_code;
      logic                 message_end;
   } btlv_rsp_type;

endpackage

@@ design/ber_tlv_stream_parser.sv @@
// Path: the input item is held in the input register, decoded, and the result is
//   captured in the result register that drives the rsp_ ports.
// Throughput: one item per cycle unless rsp_ready stalls a full result register;
//   the parser state updates in a single pass through the decode logic between the registers.
// Reset: synchronous, active high; clears both valid flags, the parser state
//   and the mode registers. Parser state also clears after each last byte.
module ber_tlv_stream_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [btlv_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [btlv_pkg::BYTE_W-1:0]        rsp_byte_out,
   output logic [btlv_pkg::KIND_W-1:0]        rsp_byte_kind,
   output logic [btlv_pkg::REC_NUM_W-1:0]     rsp_record_number,
   output logic [btlv_pkg::TAG_W-1:0]         rsp_tag_value,
   output logic [btlv_pkg::LEN_W-1:0]         rsp_value_length,
   output logic                               rsp_record_done,
   output logic [btlv_pkg::ERR_W-1:0]         rsp_error_code,
   output logic                               rsp_message_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [btlv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata
);
   import btlv_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   btlv_rsp_type      out_ff;
   btlv_rsp_type      rsp_next;
   btlv_cfg_type      cfg;
   logic              advance;

   btlv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btlv_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg),
      .rsp       (rsp_next)
   );

   // Move an item on when the result register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input item
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Capture the result item
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_byte_out      = out_ff.byte_out;
   assign rsp_byte_kind     = out_ff.byte_kind;
   assign rsp_record_number = out_ff.record_number;
   assign rsp_tag_value     = out_ff.tag_value;
   assign rsp_value_length  = out_ff.value_length;
   assign rsp_record_done   = out_ff.record_done;
   assign rsp_error_code    = out_ff.error_code;
   assign rsp_message_end   = out_ff.message_end;

   a_advance_fills : assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item lost before result register");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ready)
      else $error("input register overrun");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled item changed in input register");

endmodule

@@ design/btlv_csr.sv @@
module btlv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [btlv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic                            csr_wdata,
   output btlv_pkg::btlv_cfg_type          cfg
);
   import btlv_pkg::*;

   logic tag_mode_ff, tag_mode_in;
   logic len_mode_ff, len_mode_in;

   // Always take writes
   assign csr_ready = 1'b1;

   // Decode the write index
   always_comb begin
      tag_mode_in = tag_mode_ff;
      len_mode_in = len_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TAG_MODE: tag_mode_in = csr_wdata;
            CSR_LEN_MODE: len_mode_in = csr_wdata;
            default: begin
               tag_mode_in = tag_mode_ff;
               len_mode_in = len_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_mode_ff <= 1'b0;
         len_mode_ff <= 1'b0;
      end else begin
         tag_mode_ff <= tag_mode_in;
         len_mode_ff <= len_mode_in;
      end
   end

   assign cfg.tag_mode = tag_mode_ff;
   assign cfg.len_mode = len_mode_ff;

endmodule

@@ design/btlv_decode.sv @@
module btlv_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [btlv_pkg::BYTE_W-1:0]      data_byte,
   input  logic                             last_byte,
   input  btlv_pkg::btlv_cfg_type           cfg,
   output btlv_pkg::btlv_rsp_type           rsp
);
   import btlv_pkg::*;

   localparam logic [1:0] PH_TAG_FIRST = 2'd0;
   localparam logic [1:0] PH_TAG_MORE  = 2'd1;
   localparam logic [1:0] PH_LEN       = 2'd2;
   localparam logic [1:0] PH_VALUE     = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   logic [TAG_SEEN_W-1:0] tag_seen_ff, tag_seen_in;
   logic [TAG_W-1:0]      tag_accum_ff, tag_accum_in;
   logic [LEN_LEFT_W-1:0] len_left_ff, len_left_in;
   logic [LEN_W-1:0]      len_accum_ff, len_accum_in;
   logic [LEN_W-1:0]      value_left_ff, value_left_in;
   logic [REC_CNT_W-1:0]  rec_count_ff, rec_count_in;
   logic                  error_ff, error_in;

   logic [TAG_SEEN_W:0]   seen_inc;
   logic [LEN_W-1:0]      len_new;
   logic [LEN_W-1:0]      value_dec;
   logic                  rec_full;
   logic                  rec_room;
   logic [KIND_W-1:0]     kind;
   logic [ERR_W-1:0]      err;
   logic                  done;

   assign seen_inc  = {1'b0, tag_seen_ff} + 1'b1;
   assign len_new   = (len_left_ff == '0) ? {{(LEN_W-BYTE_W){1'b0}}, data_byte}
                                          : {len_accum_ff[LEN_W-BYTE_W-1:0], data_byte};
   assign value_dec = (value_left_ff != '0) ? value_left_ff - 1'b1 : '0;
   assign rec_full  = rec_count_ff >= REC_CNT_W'(RECORDS_MAX);
   assign rec_room  = rec_count_ff <  REC_CNT_W'(RECORDS_MAX);

   // Work out the label and the updated parser state for this byte
   always_comb begin
      phase_in      = phase_ff;
      tag_seen_in   = tag_seen_ff;
      tag_accum_in  = tag_accum_ff;
      len_left_in   = len_left_ff;
      len_accum_in  = len_accum_ff;
      value_left_in = value_left_ff;
      rec_count_in  = rec_count_ff;
      error_in      = error_ff;
      kind          = KIND_DISCARD;
      err           = ERR_NONE;
      done          = 1'b0;
      if (!error_ff) begin
         case (phase_ff)
            PH_TAG_FIRST: begin
               if (rec_full) begin
                  err      = ERR_RECORDS;
                  error_in = 1'b1;
               end else begin
                  tag_accum_in  = {{(TAG_W-BYTE_W){1'b0}}, data_byte};
                  len_accum_in  = '0;
                  len_left_in   = '0;
                  value_left_in = '0;
                  tag_seen_in   = '0;
                  if (cfg.tag_mode && data_byte[4:0] == TAG_MORE_MARK) begin
                     if (TAG_BYTES_MAX <= 1) begin
                        err      = ERR_TAG_LONG;
                        error_in = 1'b1;
                     end else begin
                        tag_seen_in = TAG_SEEN_W'(1);
                        phase_in    = PH_TAG_MORE;
                        kind        = KIND_TAG;
                     end
                  end else begin
                     phase_in = PH_LEN;
                     kind     = KIND_TAG;
                  end
               end
            end
            PH_TAG_MORE: begin
               if (data_byte[BYTE_W-1] && seen_inc >= (TAG_SEEN_W+1)'(TAG_BYTES_MAX)) begin
                  err      = ERR_TAG_LONG;
                  error_in = 1'b1;
               end else begin
                  tag_accum_in = {tag_accum_ff[TAG_W-BYTE_W-1:0], data_byte};
                  if (data_byte[BYTE_W-1]) begin
                     tag_seen_in = seen_inc[TAG_SEEN_W-1:0];
                  end else begin
                     tag_seen_in = '0;
                     phase_in    = PH_LEN;
                  end
                  kind = KIND_TAG;
               end
            end
            PH_LEN: begin
               kind = KIND_LEN;
               if (len_left_ff == '0 && cfg.len_mode && data_byte[BYTE_W-1]) begin
                  // Long form header
                  if (data_byte == LEN_LONG_1) begin
                     len_left_in = LEN_LEFT_W'(1);
                  end else if (data_byte == LEN_LONG_2) begin
                     len_left_in = LEN_LEFT_W'(2);
                  end else begin
                     kind     = KIND_DISCARD;
                     err      = ERR_BAD_LEN;
                     error_in = 1'b1;
                  end
               end else begin
                  len_accum_in = len_new;
                  len_left_in  = (len_left_ff == '0) ? '0 : len_left_ff - 1'b1;
                  // Length complete: close at once on zero length
                  if (len_left_ff <= LEN_LEFT_W'(1)) begin
                     len_left_in = '0;
                     if (len_new == '0) begin
                        done     = 1'b1;
                        phase_in = PH_TAG_FIRST;
                        if (rec_room) begin
                           rec_count_in = rec_count_ff + 1'b1;
                        end
                     end else begin
                        value_left_in = len_new;
                        phase_in      = PH_VALUE;
                     end
                  end
               end
            end
            default: begin
               kind          = KIND_VALUE;
               value_left_in = value_dec;
               if (value_dec == '0) begin
                  done     = 1'b1;
                  phase_in = PH_TAG_FIRST;
                  if (rec_room) begin
                     rec_count_in = rec_count_ff + 1'b1;
                  end
               end
            end
         endcase
         // Flag a message that ends inside a record
         if (last_byte && !error_in && phase_in != PH_TAG_FIRST) begin
            err = ERR_TRUNC;
         end
      end
   end

   // Advance the parser; drop back to reset after the last byte
   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         phase_ff      <= PH_TAG_FIRST;
         tag_seen_ff   <= '0;
         tag_accum_ff  <= '0;
         len_left_ff   <= '0;
         len_accum_ff  <= '0;
         value_left_ff <= '0;
         rec_count_ff  <= '0;
         error_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         tag_seen_ff   <= tag_seen_in;
         tag_accum_ff  <= tag_accum_in;
         len_left_ff   <= len_left_in;
         len_accum_ff  <= len_accum_in;
         value_left_ff <= value_left_in;
         rec_count_ff  <= rec_count_in;
         error_ff      <= error_in;
      end
   end

   assign rsp.byte_out      = data_byte;
   assign rsp.byte_kind     = kind;
   assign rsp.record_number = rec_count_ff[REC_NUM_W-1:0];
   assign rsp.tag_value     = tag_accum_in;
   assign rsp.value_length  = len_accum_in;
   assign rsp.record_done   = done;
   assign rsp.error_code    = err;
   assign rsp.message_end   = last_byte;

   a_rec_count_bound : assert property (@(posedge clock) disable iff (reset)
      rec_count_ff <= REC_CNT_W'(RECORDS_MAX))
      else $error("record count past limit");

   a_value_left : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> value_left_ff != '0)
      else $error("value phase with no bytes left");

   a_len_left_phase : assert property (@(posedge clock) disable iff (reset)
      len_left_ff != '0 |-> phase_ff == PH_LEN)
      else $error("length bytes pending outside length phase");

   a_err_discard : assert property (@(posedge clock) disable iff (reset)
      (err != ERR_NONE && err != ERR_TRUNC) |-> kind == KIND_DISCARD)
      else $error("error byte not discarded");

endmodule
